// ===== sv/bmp8_pkg.sv =====
// Shared types, constants and helpers of the 8-bit bitmap pixel decoder.
`timescale 1ns / 1ps

package bmp8_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned DimW     = 12;
    localparam int unsigned IdxW     = 22;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 12;
    localparam int unsigned FifoDepth = 2;

    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 2048;

    localparam logic [DimW-1:0] RST_WIDTH  = 12'd320;
    localparam logic [DimW-1:0] RST_HEIGHT = 12'd200;

    localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_RLE    = 2'd2;

    localparam logic [ByteW-1:0] ESC_EOL   = 8'd0;
    localparam logic [ByteW-1:0] ESC_EOB   = 8'd1;
    localparam logic [ByteW-1:0] ESC_DELTA = 8'd2;

    typedef enum logic [1:0] {
        ST_WRITE      = 2'd0,
        ST_WRITE_DONE = 2'd1,
        ST_DONE       = 2'd2,
        ST_DROP       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_CODE1 = 3'd0,
        PH_CODE2 = 3'd1,
        PH_DX    = 3'd2,
        PH_DY    = 3'd3,
        PH_LIT   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        CK_RUN      = 2'd0,
        CK_RUN_LAST = 2'd1,
        CK_DONE     = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [DimW-1:0]  row;
        logic [DimW-1:0]  column;
        logic [ByteW-1:0] len;
        logic [ByteW-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [DimW-1:0] width;
        logic [DimW-1:0] height;
    } t_geom;

    function automatic logic [DimW-1:0] dim_clamp(input logic [DimW-1:0] v,
                                                  input int unsigned lim);
        dim_clamp = (32'(v) > lim) ? DimW'(lim) : v;
    endfunction

    function automatic logic [DimW-1:0] col_add(input logic [DimW-1:0] c,
                                                input logic [ByteW-1:0] n);
        logic [DimW:0] s;
        s = {1'b0, c} + {5'b0, n};
        col_add = s[DimW] ? {DimW{1'b1}} : s[DimW-1:0];
    endfunction

endpackage

// ===== sv/bmp8_byte_if.sv =====
// Input byte channel of the bitmap pixel decoder.
`timescale 1ns / 1ps

interface bmp8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== sv/bmp8_pix_if.sv =====
// Frame-buffer write command channel of the bitmap pixel decoder.
`timescale 1ns / 1ps

interface bmp8_pix_if;
    logic        valid;
    logic        ready;
    logic [21:0] write_index;
    logic [7:0]  run_length;
    logic [7:0]  pixel_value;
    logic [1:0]  status;

    modport source (output valid, output write_index, output run_length,
                    output pixel_value, output status, input ready);
    modport sink   (input valid, input write_index, input run_length,
                    input pixel_value, input status, output ready);
endinterface

// ===== sv/bmp8_front.sv =====
// Byte parser: configuration registers, position tracking and command generation.
`timescale 1ns / 1ps

module bmp8_front #(
    parameter int unsigned MAX_WIDTH  = bmp8_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bmp8_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bmp8_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [bmp8_pkg::CfgDataW-1:0]   i_cfg_wdata,
    bmp8_byte_if.sink                       i_byte,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output bmp8_pkg::t_cmd                  o_q_cmd,
    output bmp8_pkg::t_geom                 o_geom
);
    import bmp8_pkg::*;

    logic [DimW-1:0]  r_img_w, r_img_h;
    logic             r_rle;
    t_phase           r_phase, n_phase;
    logic [DimW-1:0]  r_col, n_col;
    logic [DimW-1:0]  r_row, n_row;
    logic [ByteW-1:0] r_held, n_held;
    logic [ByteW-1:0] r_lit, n_lit;
    logic [1:0]       r_pad, n_pad;
    logic             r_fin, n_fin;

    logic             accept, active;
    logic [ByteW-1:0] b;
    logic [DimW-1:0]  eff_w, eff_h, cfg_h, restart_row, reset_row;
    logic [DimW-1:0]  col_inc1, col_held, col_byte;
    logic             raw_wrap, cfg_hit;

    assign i_byte.ready = !i_q_full;
    assign accept  = i_byte.valid && i_byte.ready;
    assign active  = accept && !r_fin && (r_pad == 2'd0);
    assign b       = i_byte.data_byte;

    assign eff_w   = dim_clamp(r_img_w, MAX_WIDTH);
    assign eff_h   = dim_clamp(r_img_h, MAX_HEIGHT);
    assign o_geom  = '{width: eff_w, height: eff_h};

    assign cfg_hit = i_cfg_wr_en && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT
                                     || i_cfg_index == CFG_RLE);
    assign cfg_h   = dim_clamp((i_cfg_index == CFG_HEIGHT) ? i_cfg_wdata : r_img_h, MAX_HEIGHT);
    assign restart_row = (cfg_h == '0) ? '0 : cfg_h - 1'b1;
    assign reset_row   = (dim_clamp(RST_HEIGHT, MAX_HEIGHT) == '0) ? '0
                         : dim_clamp(RST_HEIGHT, MAX_HEIGHT) - 1'b1;

    assign col_inc1 = col_add(r_col, 8'd1);
    assign col_held = col_add(r_col, r_held);
    assign col_byte = col_add(r_col, b);
    assign raw_wrap = (col_inc1 >= eff_w);

    always_comb begin
        n_phase = r_phase;
        n_col   = r_col;
        n_row   = r_row;
        n_held  = r_held;
        n_lit   = r_lit;
        n_pad   = r_pad;
        n_fin   = r_fin;
        if (accept && !r_fin) begin
            if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
            end else if (!r_rle) begin
                if (raw_wrap) begin
                    n_col = '0;
                    if (r_row == '0) begin
                        n_fin = 1'b1;
                    end else begin
                        n_row = r_row - 1'b1;
                        n_pad = 2'(~eff_w[1:0] + 2'd1);
                    end
                end else begin
                    n_col = col_inc1;
                end
            end else begin
                unique case (r_phase)
                    PH_CODE1: begin
                        n_held  = b;
                        n_phase = PH_CODE2;
                    end
                    PH_CODE2: begin
                        n_phase = PH_CODE1;
                        if (r_held != '0) begin
                            n_col = col_held;
                        end else if (b == ESC_EOL) begin
                            n_col = '0;
                            if (r_row == '0) n_fin = 1'b1;
                            else n_row = r_row - 1'b1;
                        end else if (b == ESC_EOB) begin
                            n_fin = 1'b1;
                        end else if (b == ESC_DELTA) begin
                            n_phase = PH_DX;
                        end else begin
                            n_held  = b;
                            n_lit   = b;
                            n_phase = PH_LIT;
                        end
                    end
                    PH_DX: begin
                        n_col   = col_byte;
                        n_phase = PH_DY;
                    end
                    PH_DY: begin
                        n_phase = PH_CODE1;
                        if ({4'b0, b} > r_row) n_fin = 1'b1;
                        else n_row = r_row - {4'b0, b};
                    end
                    PH_LIT: begin
                        n_lit = r_lit - 8'd1;
                        n_col = col_inc1;
                        if (r_lit == 8'd1) begin
                            n_phase = PH_CODE1;
                            n_pad   = {1'b0, r_held[0]};
                        end
                    end
                    default: begin
                        n_phase = PH_CODE1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_q_push = 1'b0;
        o_q_cmd  = '{kind: CK_RUN, row: r_row, column: r_col, len: 8'd1, value: b};
        if (active) begin
            if (!r_rle) begin
                o_q_push = 1'b1;
                if (raw_wrap && r_row == '0) o_q_cmd.kind = CK_RUN_LAST;
            end else begin
                unique case (r_phase)
                    PH_CODE2: begin
                        if (r_held != '0) begin
                            o_q_push    = 1'b1;
                            o_q_cmd.len = r_held;
                        end else if ((b == ESC_EOL && r_row == '0) || b == ESC_EOB) begin
                            o_q_push     = 1'b1;
                            o_q_cmd.kind = CK_DONE;
                        end
                    end
                    PH_DY: begin
                        if ({4'b0, b} > r_row) begin
                            o_q_push     = 1'b1;
                            o_q_cmd.kind = CK_DONE;
                        end
                    end
                    PH_LIT: begin
                        o_q_push = 1'b1;
                    end
                    default: begin
                        o_q_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RST_WIDTH;
            r_img_h <= RST_HEIGHT;
            r_rle   <= 1'b0;
            r_phase <= PH_CODE1;
            r_col   <= '0;
            r_row   <= reset_row;
            r_held  <= '0;
            r_lit   <= '0;
            r_pad   <= '0;
            r_fin   <= 1'b0;
        end else if (cfg_hit) begin
            if (i_cfg_index == CFG_WIDTH)  r_img_w <= i_cfg_wdata;
            if (i_cfg_index == CFG_HEIGHT) r_img_h <= i_cfg_wdata;
            if (i_cfg_index == CFG_RLE)    r_rle   <= i_cfg_wdata[0];
            r_phase <= PH_CODE1;
            r_col   <= '0;
            r_row   <= restart_row;
            r_held  <= '0;
            r_lit   <= '0;
            r_pad   <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_held  <= n_held;
            r_lit   <= n_lit;
            r_pad   <= n_pad;
            r_fin   <= n_fin;
        end
    end

endmodule

// ===== sv/bmp8_cmd_fifo.sv =====
// Short command queue between parser and write stage.
`timescale 1ns / 1ps

module bmp8_cmd_fifo #(
    parameter int unsigned DEPTH = bmp8_pkg::FifoDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmp8_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output bmp8_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);
    import bmp8_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= (r_wptr == PtrW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (do_pop)  r_rptr <= (r_rptr == PtrW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

// ===== sv/bmp8_back.sv =====
// Write stage: bounds check, linear index and registered result output.
`timescale 1ns / 1ps

module bmp8_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bmp8_pkg::t_geom i_geom,
    input  bmp8_pkg::t_cmd  i_cmd,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    bmp8_pix_if.source      o_pix
);
    import bmp8_pkg::*;

    logic              r_valid;
    logic [IdxW-1:0]   r_idx, n_idx;
    logic [ByteW-1:0]  r_len, n_len;
    logic [ByteW-1:0]  r_val, n_val;
    t_status           r_status, n_status;

    logic              row_ok, span_ok, ok;
    logic [DimW:0]     span;
    logic [2*DimW-1:0] prod;

    assign o_q_pop = !i_q_empty && (!r_valid || o_pix.ready);

    assign row_ok  = (i_cmd.row < i_geom.height);
    assign span    = {1'b0, i_cmd.column} + {5'b0, i_cmd.len};
    assign span_ok = (span <= {1'b0, i_geom.width});
    assign ok      = row_ok && span_ok;
    assign prod    = i_cmd.row * i_geom.width;

    always_comb begin
        unique case (i_cmd.kind)
            CK_RUN:      n_status = ok ? ST_WRITE : ST_DROP;
            CK_RUN_LAST: n_status = ok ? ST_WRITE_DONE : ST_DONE;
            default:     n_status = ST_DONE;
        endcase
        if (n_status == ST_DONE || n_status == ST_DROP) begin
            n_idx = '0;
            n_len = '0;
            n_val = '0;
        end else begin
            n_idx = IdxW'(prod + {{DimW{1'b0}}, i_cmd.column});
            n_len = i_cmd.len;
            n_val = i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_idx    <= n_idx;
            r_len    <= n_len;
            r_val    <= n_val;
            r_status <= n_status;
        end
    end

    assign o_pix.valid       = r_valid;
    assign o_pix.write_index = r_idx;
    assign o_pix.run_length  = r_len;
    assign o_pix.pixel_value = r_val;
    assign o_pix.status      = r_status;

endmodule

// ===== sv/bmp_8bit_pixel_decoder.sv =====
// Top level of the 8-bit bitmap pixel decoder (raw rows or RLE8 stream).
//
//  channel   dir  handshake          payload
//  i_byte    in   valid/ready        data_byte[7:0]
//  o_pix     out  valid/ready        write_index[21:0] run_length[7:0]
//                                    pixel_value[7:0] status[1:0]
//  i_cfg_*   in   write enable only  index[1:0] wdata[11:0]
//
//  One byte is taken every cycle while the queue is not full; a byte that yields a write
//  enters the queue at its transfer and, once the output register is free, shows on o_pix.
//  The row * width multiply in the write stage sets the cycle time.
//  Reset is synchronous; a write to the width, height or RLE register restarts the parser.
//  i_byte stalls only when the queue is full; a stalled o_pix keeps its result.
`timescale 1ns / 1ps

module bmp_8bit_pixel_decoder #(
    parameter int unsigned MAX_WIDTH  = bmp8_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bmp8_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bmp8_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [bmp8_pkg::CfgDataW-1:0] i_cfg_wdata,
    bmp8_byte_if.sink                     i_byte,
    bmp8_pix_if.source                    o_pix
);
    import bmp8_pkg::*;

    logic  q_push, q_pop, q_full, q_empty;
    t_cmd  q_in, q_out;
    t_geom geom;

    bmp8_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (i_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in),
        .o_geom      (geom)
    );

    bmp8_cmd_fifo #(
        .DEPTH (FifoDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bmp8_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_cmd     (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_pix     (o_pix)
    );

endmodule

// ===== tb/bmp_8bit_pixel_decoder_test.sv =====
// Self-checking regression of the 8-bit bitmap pixel decoder over raw rows and RLE8 streams.
`timescale 1ns / 1ps

module bmp_8bit_pixel_decoder_test;
    import bmp8_pkg::*;

    localparam int unsigned MAX_W = DEF_MAX_WIDTH;
    localparam int unsigned MAX_H = DEF_MAX_HEIGHT;
    localparam int unsigned COL_CEIL = 4095;
    localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
    localparam logic [ByteW-1:0] RLE_ESCAPE = 8'd0;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [IdxW-1:0]  idx;
        logic [ByteW-1:0] len;
        logic [ByteW-1:0] val;
        t_status          st;
    } t_pix_write;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_wdata = '0;

    bmp8_byte_if byte_ch ();
    bmp8_pix_if  pix_ch ();

    bmp_8bit_pixel_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (byte_ch),
        .o_pix       (pix_ch)
    );

    // register copies and decoder state of the predictor
    logic [CfgDataW-1:0] reg_width;
    logic [CfgDataW-1:0] reg_height;
    logic                reg_rle;
    t_phase              dec_phase;
    int unsigned         dec_col;
    int unsigned         dec_row;
    logic [ByteW-1:0]    dec_held;
    logic [ByteW-1:0]    dec_lit_left;
    int unsigned         dec_pad;
    bit                  dec_done;

    t_pix_write pending_writes[$];

    bit idle_on = 1'b1;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int sink_stall = 0;
    int stuck_cycles = 0;
    int fail_count = 0;
    int bytes_sent = 0;
    int decoded_bytes = 0;
    int geometries = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned eff_width();
        return (reg_width > MAX_W) ? MAX_W : reg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (reg_height > MAX_H) ? MAX_H : reg_height;
    endfunction

    function automatic int unsigned sat_col(input int unsigned c);
        return (c > COL_CEIL) ? COL_CEIL : c;
    endfunction

    function automatic void restart_decoder();
        int unsigned h;
        h = eff_height();
        dec_phase = PH_CODE1;
        dec_col = 0;
        dec_row = (h != 0) ? h - 1 : 0;
        dec_held = '0;
        dec_lit_left = '0;
        dec_pad = 0;
        dec_done = 1'b0;
    endfunction

    function automatic void push_write(input int unsigned idx, input int unsigned len,
                                       input logic [ByteW-1:0] val, input t_status st);
        t_pix_write cmd;
        if (st == ST_DONE || st == ST_DROP) begin
            idx = 0;
            len = 0;
            val = '0;
        end
        cmd.idx = IdxW'(idx);
        cmd.len = ByteW'(len);
        cmd.val = val;
        cmd.st = st;
        pending_writes.push_back(cmd);
    endfunction

    function automatic void put_run(input int unsigned len, input logic [ByteW-1:0] val);
        int unsigned w, h, idx;
        bit in_img;
        w = eff_width();
        h = eff_height();
        in_img = dec_row < h && dec_col + len <= w;
        idx = dec_row * w + dec_col;
        dec_col = sat_col(dec_col + len);
        push_write(idx, len, val, in_img ? ST_WRITE : ST_DROP);
    endfunction

    function automatic void finish_image();
        dec_done = 1'b1;
        push_write(0, 0, '0, ST_DONE);
    endfunction

    function automatic void decode_byte(input logic [ByteW-1:0] b);
        int unsigned w, h, idx;
        bit in_img;
        w = eff_width();
        h = eff_height();
        if (dec_done) return;
        if (dec_pad != 0) begin
            dec_pad--;
            return;
        end
        if (!reg_rle) begin
            in_img = dec_col < w && dec_row < h;
            idx = dec_row * w + dec_col;
            dec_col = sat_col(dec_col + 1);
            if (dec_col >= w) begin
                dec_col = 0;
                if (dec_row == 0) begin
                    dec_done = 1'b1;
                    push_write(idx, 1, b, in_img ? ST_WRITE_DONE : ST_DONE);
                    return;
                end
                dec_row--;
                dec_pad = (4 - (w & 3)) & 3;
            end
            push_write(idx, 1, b, in_img ? ST_WRITE : ST_DROP);
            return;
        end
        case (dec_phase)
            PH_CODE2: begin
                dec_phase = PH_CODE1;
                if (dec_held != 0) begin
                    put_run(dec_held, b);
                end else if (b == ESC_EOL) begin
                    dec_col = 0;
                    if (dec_row == 0) finish_image();
                    else dec_row--;
                end else if (b == ESC_EOB) begin
                    finish_image();
                end else if (b == ESC_DELTA) begin
                    dec_phase = PH_DX;
                end else begin
                    dec_held = b;
                    dec_lit_left = b;
                    dec_phase = PH_LIT;
                end
            end
            PH_DX: begin
                dec_col = sat_col(dec_col + b);
                dec_phase = PH_DY;
            end
            PH_DY: begin
                dec_phase = PH_CODE1;
                if (b > dec_row) finish_image();
                else dec_row -= b;
            end
            PH_LIT: begin
                dec_lit_left = dec_lit_left - 8'd1;
                if (dec_lit_left == 0) begin
                    dec_phase = PH_CODE1;
                    dec_pad = dec_held[0];
                end
                put_run(1, b);
            end
            default: begin
                dec_held = b;
                dec_phase = PH_CODE2;
            end
        endcase
    endfunction

    task automatic check_write();
        t_pix_write want, got;
        got.idx = pix_ch.write_index;
        got.len = pix_ch.run_length;
        got.val = pix_ch.pixel_value;
        got.st = t_status'(pix_ch.status);
        status_seen[pix_ch.status]++;
        if (pending_writes.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: unexpected command idx %0d len %0d value %0d status %0d",
                         $time, got.idx, got.len, got.val, got.st);
            return;
        end
        want = pending_writes.pop_front();
        if (got.idx !== want.idx || got.len !== want.len || got.val !== want.val ||
            got.st !== want.st) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: expected idx %0d len %0d value %0d status %0d, got %0d %0d %0d %0d",
                         $time, want.idx, want.len, want.val, want.st,
                         got.idx, got.len, got.val, got.st);
        end
    endtask

    // output side: check each transfer, then decide ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && pix_ch.valid && pix_ch.ready) check_write();
        if (hold_seen != hold_reqs) begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_reqs;
        end
        if (hold_left != 0) begin
            hold_left--;
            pix_ch.ready <= 1'b0;
        end else if (sink_stall != 0) begin
            sink_stall--;
            pix_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            sink_stall = $urandom_range(0, 18);
            pix_ch.ready <= 1'b0;
        end else begin
            pix_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d commands outstanding",
                         $time, stuck_cycles, pending_writes.size());
                $display("bmp_8bit_pixel_decoder regression: fail");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [ByteW-1:0] b);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        bytes_sent++;
        if (!dec_done) decoded_bytes++;
        decode_byte(b);
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_WIDTH: reg_width = value;
            CFG_HEIGHT: reg_height = value;
            CFG_RLE: reg_rle = value[0];
            default: return;
        endcase
        restart_decoder();
    endtask

    task automatic set_geometry(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h,
                                input logic mode);
        logic [CfgDataW-1:0] mode_word;
        mode_word = CfgDataW'($urandom);
        mode_word[0] = mode;
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_RLE, mode_word);
        geometries++;
    endtask

    task automatic send_rle_chunk();
        int unsigned pick, n;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
            send_byte(ByteW'(n));
            send_byte(ByteW'($urandom));
        end else if (pick < 60) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(3, 9);
            send_byte(RLE_ESCAPE);
            send_byte(ByteW'(n));
            repeat (n + (n & 1)) send_byte(ByteW'($urandom));
        end else if (pick < 72) begin
            send_byte(RLE_ESCAPE);
            send_byte(ESC_EOL);
        end else if (pick < 84) begin
            send_byte(RLE_ESCAPE);
            send_byte(ESC_DELTA);
            send_byte(($urandom_range(0, 9) == 0) ? 8'hFF : ByteW'($urandom_range(0, 6)));
            send_byte(($urandom_range(0, 9) == 0) ? ByteW'($urandom)
                                                   : ByteW'($urandom_range(0, 2)));
        end else if (pick < 87) begin
            send_byte(RLE_ESCAPE);
            send_byte(ESC_EOB);
        end else if (pick < 88) begin
            // push the column into saturation, then try a write there
            repeat (17) begin
                send_byte(RLE_ESCAPE);
                send_byte(ESC_DELTA);
                send_byte(8'hFF);
                send_byte(8'h00);
            end
            send_byte(8'd1);
            send_byte(ByteW'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(ByteW'($urandom));
        end
    endtask

    task automatic test_raw_rows();
        logic [ByteW-1:0] seq [8] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h02, 8'h80, 8'h7F};
        set_geometry(12'd3, 12'd2, 1'b0);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_rle_escapes();
        logic [ByteW-1:0] seq [18] = '{8'h04, 8'hFF, 8'h00, 8'h00,
                                      8'h00, 8'h03, 8'h01, 8'h80, 8'hFE, 8'h00,
                                      8'h00, 8'h02, 8'hFF, 8'h00,
                                      8'h01, 8'h33, 8'h00, 8'h00};
        set_geometry(12'd4, 12'd2, 1'b1);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_limits();
        set_geometry(12'd0, 12'd2, 1'b0);
        send_byte(8'hC3);
        send_byte(8'h3C);
        set_geometry(12'd2, 12'd0, 1'b0);
        send_byte(8'h96);
        send_byte(8'h69);
        set_geometry(12'hFFF, 12'hFFF, 1'b1);
        send_byte(8'h02);
        send_byte(8'h44);
        write_reg(CFG_SPARE, 12'hABC);
        send_byte(8'h03);
        send_byte(8'h99);
        send_byte(RLE_ESCAPE);
        send_byte(ESC_EOB);
        set_geometry(12'd5, 12'd1, 1'b1);
        send_byte(RLE_ESCAPE);
        send_byte(ESC_DELTA);
        send_byte(8'h01);
        send_byte(8'h01);
    endtask

    task automatic test_raw_random(input int budget);
        int stop_at, cap;
        logic [CfgDataW-1:0] w, h;
        stop_at = decoded_bytes + budget;
        while (decoded_bytes < stop_at) begin
            case ($urandom_range(0, 19))
                0: w = 12'd0;
                1: w = 12'd1;
                2: w = 12'd2048;
                3: w = 12'hFFF;
                default: w = CfgDataW'($urandom_range(1, 9));
            endcase
            case ($urandom_range(0, 19))
                0: h = 12'd0;
                1: h = 12'd2048;
                default: h = CfgDataW'($urandom_range(1, 4));
            endcase
            set_geometry(w, h, 1'b0);
            cap = decoded_bytes + $urandom_range(10, 50);
            while (!dec_done && decoded_bytes < cap) send_byte(ByteW'($urandom));
            if (dec_done) send_byte(ByteW'($urandom));
        end
    endtask

    task automatic test_rle_random(input int budget);
        int stop_at, cap;
        logic [CfgDataW-1:0] w, h;
        stop_at = decoded_bytes + budget;
        while (decoded_bytes < stop_at) begin
            case ($urandom_range(0, 19))
                0: w = 12'd1;
                1: w = 12'd2048;
                2: w = 12'hFFF;
                default: w = CfgDataW'($urandom_range(4, 40));
            endcase
            case ($urandom_range(0, 19))
                0: h = 12'd0;
                1: h = 12'd2048;
                default: h = CfgDataW'($urandom_range(1, 8));
            endcase
            set_geometry(w, h, 1'b1);
            cap = decoded_bytes + $urandom_range(30, 90);
            while (!dec_done && decoded_bytes < cap) send_rle_chunk();
        end
    endtask

    task automatic test_output_backpressure();
        set_geometry(12'd2048, 12'd2048, 1'b1);
        hold_reqs++;
        repeat (40) begin
            send_byte(8'd1);
            send_byte(ByteW'($urandom));
        end
        wait_drained();
    endtask

    initial begin
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        reg_width = RST_WIDTH;
        reg_height = RST_HEIGHT;
        reg_rle = 1'b0;
        restart_decoder();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_raw_rows();
        test_rle_escapes();
        test_limits();
        test_raw_random(420);
        test_rle_random(650);
        test_output_backpressure();
        idle_on = 1'b0;
        test_rle_random(150);
        test_raw_random(80);
        wait_drained();

        $display("covered %0d geometries in raw and RLE8 modes: %0d bytes sent, %0d decoded",
                 geometries, bytes_sent, decoded_bytes);
        $display("commands: %0d writes, %0d last writes, %0d image ends, %0d drops; %0d failures",
                 status_seen[ST_WRITE], status_seen[ST_WRITE_DONE], status_seen[ST_DONE],
                 status_seen[ST_DROP], fail_count);
        if (fail_count == 0) begin
            $display("bmp_8bit_pixel_decoder regression: pass");
        end else begin
            $display("bmp_8bit_pixel_decoder regression: fail");
        end
        $finish;
    end

endmodule
